@@ rtl/core/adq_pkg.sv @@
// Shared constants and types for the arcball drag quaternion unit.
package adq_pkg;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int COORD_BITS_DEF = 12;
   localparam int SIZE_W         = 13;
   localparam int OUT_W          = 18;
   localparam int SQRT_GUARD     = 4;
   localparam int OUT_MAX        = 131071;
   localparam int OUT_MIN        = -131072;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [0:0] {
      CSR_VIEWPORT_WIDTH  = 1'b0,
      CSR_VIEWPORT_HEIGHT = 1'b1
   } csr_index_type;

endpackage

@@ rtl/core/adq_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module adq_div #(
   parameter int NW = 30,
   parameter int DW = 13,
   parameter int QW = 30,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic [DW-1:0] rem_ff  [QW];
   logic [DW-1:0] rem_in  [QW];
   logic [QW-1:0] lo_ff   [QW];
   logic [QW-1:0] lo_in   [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [QW-1:0] quo_in  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [SW-1:0] side_ff [QW];
   logic          vld_ff  [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [DW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [QW-1:0] lo_prev;
      logic [QW-1:0] quo_prev;
      logic [SW-1:0] side_prev;
      logic          vld_prev;
      logic [DW:0]   trial;
      logic          ge;

      if (i == 0) begin : g_first
         // numerator bits above the quotient range are known to be below the divisor
         assign rem_prev  = DW'(in_num >> QW);
         assign lo_prev   = QW'(in_num);
         assign quo_prev  = '0;
         assign den_prev  = in_den;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign lo_prev   = lo_ff[i-1];
         assign quo_prev  = quo_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign side_prev = side_ff[i-1];
         assign vld_prev  = vld_ff[i-1];
      end

      assign trial     = {rem_prev, lo_prev[QW-1]};
      assign ge        = trial >= {1'b0, den_prev};
      assign rem_in[i] = ge ? DW'(trial - {1'b0, den_prev}) : trial[DW-1:0];
      assign lo_in[i]  = lo_prev << 1;
      assign quo_in[i] = (quo_prev << 1) | QW'(ge);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in[i];
            lo_ff[i]   <= lo_in[i];
            quo_ff[i]  <= quo_in[i];
            den_ff[i]  <= den_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

@@ rtl/core/adq_sqrt.sv @@
// Pipelined integer square root, two radicand bits per stage, rounded to nearest.
module adq_sqrt #(
   parameter int VW = 48,
   parameter int SW = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [VW-1:0]     in_val,
   input  logic [SW-1:0]     in_side,
   output logic              out_valid,
   output logic [VW/2:0]     out_root,
   output logic [SW-1:0]     out_side
);

   localparam int RW  = VW / 2;
   localparam int RMW = RW + 3;

   logic [RMW-1:0] rem_ff  [RW];
   logic [RMW-1:0] rem_in  [RW];
   logic [RW-1:0]  root_ff [RW];
   logic [RW-1:0]  root_in [RW];
   logic [VW-1:0]  val_ff  [RW];
   logic [SW-1:0]  side_ff [RW];
   logic           vld_ff  [RW];

   logic [RW:0]    round_ff;
   logic [RW:0]    round_in;
   logic [SW-1:0]  oside_ff;
   logic           ovld_ff;

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic [RMW-1:0] rem_prev;
      logic [RW-1:0]  root_prev;
      logic [VW-1:0]  val_prev;
      logic [SW-1:0]  side_prev;
      logic           vld_prev;
      logic [RMW-1:0] acc;
      logic [RMW-1:0] trial;
      logic           ge;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign val_prev  = in_val;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign val_prev  = val_ff[i-1];
         assign side_prev = side_ff[i-1];
         assign vld_prev  = vld_ff[i-1];
      end

      assign acc        = {rem_prev[RMW-3:0], val_prev[VW-1 -: 2]};
      assign trial      = RMW'({root_prev, 2'b01});
      assign ge         = acc >= trial;
      assign rem_in[i]  = ge ? acc - trial : acc;
      assign root_in[i] = {root_prev[RW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            val_ff[i]  <= val_prev << 2;
            side_ff[i] <= side_prev;
         end
      end
   end

   // remainder is v - root^2; round up when it exceeds root
   assign round_in = (rem_ff[RW-1] > RMW'(root_ff[RW-1])) ?
                     (RW+1)'(root_ff[RW-1]) + (RW+1)'(1) : (RW+1)'(root_ff[RW-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (en) begin
         ovld_ff <= vld_ff[RW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         round_ff <= round_in;
         oside_ff <= side_ff[RW-1];
      end
   end

   assign out_valid = ovld_ff;
   assign out_root  = round_ff;
   assign out_side  = oside_ff;

endmodule

@@ rtl/core/adq_lane.sv @@
// One drag point: pixel to plane coordinate, lift onto the sphere or the rim.
module adq_lane #(
   parameter int FRAC_BITS  = 16,
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [COORD_BITS-1:0]         in_x,
   input  logic [COORD_BITS-1:0]         in_y,
   input  logic [adq_pkg::SIZE_W-1:0]    in_width,
   input  logic [adq_pkg::SIZE_W-1:0]    in_height,
   output logic                          out_valid,
   output logic signed [FRAC_BITS+2:0]   out_px,
   output logic signed [FRAC_BITS+2:0]   out_py,
   output logic signed [FRAC_BITS+2:0]   out_pz
);

   import adq_pkg::*;

   localparam int MW   = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
   localparam int NW1  = MW + FRAC_BITS + 1;
   localparam int LIMB = FRAC_BITS + 3;
   localparam int KMAX = NW1 - LIMB;
   localparam int KW   = $clog2(KMAX + 1);
   localparam int SQW  = 2 * LIMB + 1;
   localparam int VW   = 2 * FRAC_BITS + 16;
   localparam int RW   = VW / 2;
   localparam int DW2  = FRAC_BITS + 8;
   localparam int NW2  = 2 * FRAC_BITS + 8;
   localparam int QW2  = FRAC_BITS + 2;
   localparam int PW   = FRAC_BITS + 3;
   localparam int ZW   = FRAC_BITS + 1;
   localparam int SSW  = 1 + 2 * LIMB + 2;
   localparam int ASW  = 1 + ZW + 2 * LIMB + 1;

   localparam logic [SQW-1:0] ONE2 = SQW'(1) << (2 * FRAC_BITS);

   // plane coordinates, one divider per axis
   logic [COORD_BITS-1:0] coord [2];
   logic [SIZE_W-1:0]     size  [2];
   logic                  pv    [2];
   logic [NW1-1:0]        pq    [2];
   logic                  pneg  [2];

   assign coord[0] = in_x;
   assign coord[1] = in_y;
   assign size[0]  = in_width;
   assign size[1]  = in_height;

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis
      logic [SIZE_W-1:0]   s;
      logic [COORD_BITS:0] twice;
      logic                neg;
      logic [MW-1:0]       mag;
      logic [NW1-1:0]      num;

      assign s     = (size[ax] == '0) ? SIZE_W'(1) : size[ax];
      assign twice = {coord[ax], 1'b0};
      assign neg   = MW'(twice) < MW'(s);
      assign mag   = neg ? MW'(s) - MW'(twice) : MW'(twice) - MW'(s);
      assign num   = (NW1'(mag) << FRAC_BITS) + NW1'(s >> 1);

      adq_div #(.NW(NW1), .DW(SIZE_W), .QW(NW1), .SW(1)) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (in_valid),
         .in_num    (num),
         .in_den    (s),
         .in_side   (neg),
         .out_valid (pv[ax]),
         .out_quo   (pq[ax]),
         .out_side  (pneg[ax])
      );
   end

   // huge coordinates: common right shift until both are below 8
   logic [NW1-1:0]  orv;
   logic [KW-1:0]   k;
   logic [LIMB-1:0] b_a_ff, b_b_ff;
   logic            b_shift_ff, b_nx_ff, b_ny_ff, b_vld_ff;

   assign orv = pq[0] | pq[1];

   always_comb begin
      k = KW'(KMAX);
      for (int kk = KMAX; kk >= 0; kk--) begin
         if (((orv >> kk) >> LIMB) == '0) begin
            k = KW'(kk);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= pv[0] & pv[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_a_ff     <= LIMB'(pq[0] >> k);
         b_b_ff     <= LIMB'(pq[1] >> k);
         b_shift_ff <= (k != '0);
         b_nx_ff    <= pneg[0];
         b_ny_ff    <= pneg[1];
      end
   end

   // squared radius
   logic [2*LIMB-1:0] sq_a, sq_b;
   logic [SQW-1:0]    c_n_ff;
   logic [LIMB-1:0]   c_a_ff, c_b_ff;
   logic              c_shift_ff, c_nx_ff, c_ny_ff, c_vld_ff;

   assign sq_a = b_a_ff * b_a_ff;
   assign sq_b = b_b_ff * b_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_n_ff     <= SQW'(sq_a) + SQW'(sq_b);
         c_a_ff     <= b_a_ff;
         c_b_ff     <= b_b_ff;
         c_shift_ff <= b_shift_ff;
         c_nx_ff    <= b_nx_ff;
         c_ny_ff    <= b_ny_ff;
      end
   end

   // one shared root: lift height inside, rim length outside
   logic           in_disk;
   logic [VW-1:0]  sq_val;
   logic [SSW-1:0] sq_side_in, sq_side_out;
   logic           s_vld;
   logic [RW:0]    root;

   assign in_disk    = !c_shift_ff && (c_n_ff <= ONE2);
   assign sq_val     = in_disk ? VW'(ONE2 - c_n_ff) : (VW'(c_n_ff) << (2 * SQRT_GUARD));
   assign sq_side_in = {in_disk, c_a_ff, c_b_ff, c_nx_ff, c_ny_ff};

   adq_sqrt #(.VW(VW), .SW(SSW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_vld_ff),
      .in_val    (sq_val),
      .in_side   (sq_side_in),
      .out_valid (s_vld),
      .out_root  (root),
      .out_side  (sq_side_out)
   );

   // rim normalization
   logic            e_inside, e_nx, e_ny;
   logic [LIMB-1:0] e_a, e_b;
   logic [DW2-1:0]  den;
   logic [NW2-1:0]  num_a, num_b;
   logic [ASW-1:0]  da_side_in, da_side_out;
   logic            da_vld, db_vld;
   logic [QW2-1:0]  qa, qb;
   logic            db_ny;

   assign {e_inside, e_a, e_b, e_nx, e_ny} = sq_side_out;
   assign den   = (DW2'(root) == '0) ? DW2'(1) : DW2'(root);
   assign num_a = (NW2'(e_a) << (FRAC_BITS + SQRT_GUARD)) + NW2'(den >> 1);
   assign num_b = (NW2'(e_b) << (FRAC_BITS + SQRT_GUARD)) + NW2'(den >> 1);
   assign da_side_in = {e_inside, ZW'(root), e_a, e_b, e_nx};

   adq_div #(.NW(NW2), .DW(DW2), .QW(QW2), .SW(ASW)) u_rim_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_vld),
      .in_num    (num_a),
      .in_den    (den),
      .in_side   (da_side_in),
      .out_valid (da_vld),
      .out_quo   (qa),
      .out_side  (da_side_out)
   );

   adq_div #(.NW(NW2), .DW(DW2), .QW(QW2), .SW(1)) u_rim_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_vld),
      .in_num    (num_b),
      .in_den    (den),
      .in_side   (e_ny),
      .out_valid (db_vld),
      .out_quo   (qb),
      .out_side  (db_ny)
   );

   // pick sphere or rim point, restore signs
   logic            f_inside, f_nx;
   logic [ZW-1:0]   f_z;
   logic [LIMB-1:0] f_a, f_b;
   logic [PW-1:0]   mag_x, mag_y;
   logic signed [PW-1:0] px_in, py_in, pz_in;
   logic signed [PW-1:0] px_ff, py_ff, pz_ff;
   logic            o_vld_ff;

   assign {f_inside, f_z, f_a, f_b, f_nx} = da_side_out;
   assign mag_x = f_inside ? PW'(f_a) : PW'(qa);
   assign mag_y = f_inside ? PW'(f_b) : PW'(qb);
   assign px_in = f_nx  ? -signed'(mag_x) : signed'(mag_x);
   assign py_in = db_ny ? -signed'(mag_y) : signed'(mag_y);
   assign pz_in = f_inside ? signed'(PW'(f_z)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (en) begin
         o_vld_ff <= da_vld & db_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
      end
   end

   assign out_valid = o_vld_ff;
   assign out_px    = px_ff;
   assign out_py    = py_ff;
   assign out_pz    = pz_ff;

endmodule

@@ rtl/core/adq_merge.sv @@
// Cross and dot product of the two sphere points, rounding and saturation.
module adq_merge #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [FRAC_BITS+2:0]       p0x,
   input  logic signed [FRAC_BITS+2:0]       p0y,
   input  logic signed [FRAC_BITS+2:0]       p0z,
   input  logic signed [FRAC_BITS+2:0]       p1x,
   input  logic signed [FRAC_BITS+2:0]       p1y,
   input  logic signed [FRAC_BITS+2:0]       p1z,
   output logic                              out_valid,
   output logic signed [adq_pkg::OUT_W-1:0]  quat_x,
   output logic signed [adq_pkg::OUT_W-1:0]  quat_y,
   output logic signed [adq_pkg::OUT_W-1:0]  quat_z,
   output logic signed [adq_pkg::OUT_W-1:0]  quat_w
);

   import adq_pkg::*;

   localparam int PW   = FRAC_BITS + 3;
   localparam int PRW  = 2 * PW;
   localparam int SUMW = PRW + 2;
   localparam int EW   = (FRAC_BITS + 9 > 19) ? FRAC_BITS + 9 : 19;

   localparam logic signed [EW-1:0] SAT_HI   = EW'(OUT_MAX);
   localparam logic signed [EW-1:0] SAT_LO   = EW'(OUT_MIN);
   localparam logic signed [EW-1:0] W_LO_RAW = -(signed'(EW'(1)) <<< FRAC_BITS);
   localparam logic signed [EW-1:0] W_LO     = (W_LO_RAW < SAT_LO) ? SAT_LO : W_LO_RAW;
   localparam logic [SUMW-1:0]      HALF     = SUMW'(1) << (FRAC_BITS - 1);

   function automatic logic signed [OUT_W-1:0] round_sat(
      input logic signed [SUMW-1:0] s,
      input logic signed [EW-1:0]   lo
   );
      logic [SUMW-1:0]      mag;
      logic [SUMW-1:0]      m;
      logic signed [EW-1:0] r;
      mag = s[SUMW-1] ? unsigned'(-s) : unsigned'(s);
      m   = (mag + HALF) >> FRAC_BITS;
      r   = s[SUMW-1] ? -signed'(EW'(m)) : signed'(EW'(m));
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < lo) begin
         r = lo;
      end
      return OUT_W'(r);
   endfunction

   logic signed [PRW-1:0] m_yz_ff, m_zy_ff, m_xz_ff, m_zx_ff, m_xy_ff, m_yx_ff;
   logic signed [PRW-1:0] m_xx_ff, m_yy_ff, m_zz_ff;
   logic signed [SUMW-1:0] sx_ff, sy_ff, sz_ff, sw_ff;
   logic signed [OUT_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic v1_ff, v2_ff, v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_yz_ff <= p0y * p1z;
         m_zy_ff <= p1y * p0z;
         m_xz_ff <= p1x * p0z;
         m_zx_ff <= p0x * p1z;
         m_xy_ff <= p0x * p1y;
         m_yx_ff <= p1x * p0y;
         m_xx_ff <= p0x * p1x;
         m_yy_ff <= p0y * p1y;
         m_zz_ff <= p0z * p1z;

         sx_ff <= SUMW'(m_yz_ff) - SUMW'(m_zy_ff);
         sy_ff <= SUMW'(m_xz_ff) - SUMW'(m_zx_ff);
         sz_ff <= SUMW'(m_xy_ff) - SUMW'(m_yx_ff);
         sw_ff <= SUMW'(m_xx_ff) + SUMW'(m_yy_ff) + SUMW'(m_zz_ff);

         qx_ff <= round_sat(sx_ff, SAT_LO);
         qy_ff <= round_sat(sy_ff, SAT_LO);
         qz_ff <= round_sat(sz_ff, SAT_LO);
         qw_ff <= round_sat(sw_ff, W_LO);
      end
   end

   assign out_valid = v3_ff;
   assign quat_x    = qx_ff;
   assign quat_y    = qy_ff;
   assign quat_z    = qz_ff;
   assign quat_w    = qw_ff;

endmodule

@@ rtl/core/arcball_drag_quaternion_unit.sv @@
// Arcball drag quaternion unit: turns a mouse drag into an unnormalized rotation quaternion.
// Each drag transaction (start and end pixel) runs through two identical point lanes, one per
// pixel, and a merge stage forming the cross product and the clamped dot product in signed
// Q2.FRAC_BITS. The unit is fully pipelined and accepts one transaction per cycle while the
// output is not stalled. A stalled result freezes the whole pipeline, so req_ready follows
// rsp_ready whenever a result is held. Viewport registers must be written through the csr port
// only while idle; the unit itself does not enforce this. A size of zero is treated as one.
module arcball_drag_quaternion_unit #(
   parameter int FRAC_BITS  = adq_pkg::FRAC_BITS_DEF,
   parameter int COORD_BITS = adq_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [COORD_BITS-1:0]             req_start_x,
   input  logic [COORD_BITS-1:0]             req_start_y,
   input  logic [COORD_BITS-1:0]             req_end_x,
   input  logic [COORD_BITS-1:0]             req_end_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [adq_pkg::OUT_W-1:0]  rsp_quat_x,
   output logic signed [adq_pkg::OUT_W-1:0]  rsp_quat_y,
   output logic signed [adq_pkg::OUT_W-1:0]  rsp_quat_z,
   output logic signed [adq_pkg::OUT_W-1:0]  rsp_quat_w,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  adq_pkg::csr_index_type            csr_index,
   input  logic [adq_pkg::SIZE_W-1:0]        csr_wdata
);

   import adq_pkg::*;

   localparam int PW = FRAC_BITS + 3;

   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VIEWPORT_WIDTH: begin
               width_in = csr_wdata;
            end
            CSR_VIEWPORT_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign csr_ready = 1'b1;

   logic en;
   logic accept;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid && en;

   logic                 l0_vld, l1_vld;
   logic signed [PW-1:0] p0x, p0y, p0z, p1x, p1y, p1z;

   adq_lane #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_lane_start (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (accept),
      .in_x      (req_start_x),
      .in_y      (req_start_y),
      .in_width  (width_ff),
      .in_height (height_ff),
      .out_valid (l0_vld),
      .out_px    (p0x),
      .out_py    (p0y),
      .out_pz    (p0z)
   );

   adq_lane #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_lane_end (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (accept),
      .in_x      (req_end_x),
      .in_y      (req_end_y),
      .in_width  (width_ff),
      .in_height (height_ff),
      .out_valid (l1_vld),
      .out_px    (p1x),
      .out_py    (p1y),
      .out_pz    (p1z)
   );

   adq_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (l0_vld & l1_vld),
      .p0x       (p0x),
      .p0y       (p0y),
      .p0z       (p0z),
      .p1x       (p1x),
      .p1y       (p1y),
      .p1z       (p1z),
      .out_valid (rsp_valid),
      .quat_x    (rsp_quat_x),
      .quat_y    (rsp_quat_y),
      .quat_z    (rsp_quat_z),
      .quat_w    (rsp_quat_w)
   );

endmodule
